>>> hdl/dns_soa_ttl_extractor_macros.svh
// Assertion macros shared by the DNS SOA TTL extractor RTL.
`ifndef DNS_SOA_TTL_EXTRACTOR_MACROS_SVH
`define DNS_SOA_TTL_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication on every clock edge outside reset.
`define DST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DST_ASSERT(label, prop, msg)
`define DST_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> hdl/dst_pkg.sv
// Shared types and constants of the DNS SOA TTL extractor.
`default_nettype none

package dst_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TTL_W   = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned FBC_W   = 4;

    localparam logic [FBC_W-1:0]   HDR_LAST    = 4'd11;
    localparam logic [FBC_W-1:0]   QFIXED_LAST = 4'd3;
    localparam logic [FBC_W-1:0]   RFIXED_LAST = 4'd9;
    localparam logic [BYTE_W-1:0]  PTR_MASK    = 8'hC0;
    localparam logic [BYTE_W-1:0]  NAME_END    = 8'h00;
    localparam logic [COUNT_W-1:0] SOA_TYPE    = 16'd6;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_SOA    = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [TTL_W-1:0]   soa_ttl;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/dst_byte_if.sv
// Byte channel carrying one message byte and its end mark per item.
`default_nettype none

interface dst_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/dst_result_if.sv
// Result channel carrying the status and SOA TTL of one message.
`default_nettype none

interface dst_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] soa_ttl;

    modport source (output valid, output status, output soa_ttl, input ready);
    modport sink   (input valid, input status, input soa_ttl, output ready);
endinterface

`default_nettype wire

>>> hdl/dst_parse.sv
// Parser state and per-byte update of the DNS response walk.
`default_nettype none

module dst_parse (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [dst_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                      last_byte,
    output logic                           res_valid,
    output dst_pkg::result_t               res
);
    import dst_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_NAME   = 4'd1,
        PH_LABEL  = 4'd2,
        PH_PTR    = 4'd3,
        PH_QFIXED = 4'd4,
        PH_RFIXED = 4'd5,
        PH_RDATA  = 4'd6,
        PH_NONE   = 4'd7,
        PH_FOUND  = 4'd8
    } phase_t;

    phase_t               phase_reg,     phase_next;
    logic [FBC_W-1:0]     fbc_reg,       fbc_next;
    logic [COUNT_W-1:0]   question_reg,  question_next;
    logic [COUNT_W-1:0]   answer_reg,    answer_next;
    logic [COUNT_W-1:0]   authority_reg, authority_next;
    logic [BYTE_W-1:0]    label_reg,     label_next;
    logic [COUNT_W-1:0]   rtype_reg,     rtype_next;
    logic [TTL_W-1:0]     ttl_reg,       ttl_next;
    logic [COUNT_W-1:0]   rdata_reg,     rdata_next;

    logic go_item;
    logic go_name;
    logic go_record;

    always_comb
    begin
        phase_next     = phase_reg;
        fbc_next       = fbc_reg;
        question_next  = question_reg;
        answer_next    = answer_reg;
        authority_next = authority_reg;
        label_next     = label_reg;
        rtype_next     = rtype_reg;
        ttl_next       = ttl_reg;
        rdata_next     = rdata_reg;
        go_item        = 1'b0;
        go_name        = 1'b0;
        go_record      = 1'b0;
        res_valid      = 1'b0;
        res.status     = ST_TRUNCATED;
        res.soa_ttl    = '0;

        if (step)
        begin
            // A new record starts: clear the fields gathered from its fixed part.
            if (phase_reg == PH_RFIXED && fbc_reg == '0)
            begin
                rtype_next = '0;
                ttl_next   = '0;
                rdata_next = '0;
            end

            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (fbc_reg == 4'd4 || fbc_reg == 4'd5)
                        question_next = {question_reg[COUNT_W-BYTE_W-1:0], data_byte};
                    else if (fbc_reg == 4'd6 || fbc_reg == 4'd7)
                        answer_next = {answer_reg[COUNT_W-BYTE_W-1:0], data_byte};
                    else if (fbc_reg == 4'd8 || fbc_reg == 4'd9)
                        authority_next = {authority_reg[COUNT_W-BYTE_W-1:0], data_byte};
                    if (fbc_reg == HDR_LAST)
                        go_item = 1'b1;
                    else
                        fbc_next = fbc_reg + 4'd1;
                end
                PH_NAME:
                begin
                    if ((data_byte & PTR_MASK) == PTR_MASK)
                        phase_next = PH_PTR;
                    else if (data_byte == NAME_END)
                        go_name = 1'b1;
                    else
                    begin
                        label_next = data_byte;
                        phase_next = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    label_next = label_reg - 8'd1;
                    if (label_next == '0)
                        phase_next = PH_NAME;
                end
                PH_PTR:
                begin
                    go_name = 1'b1;
                end
                PH_QFIXED:
                begin
                    if (fbc_reg >= QFIXED_LAST)
                    begin
                        question_next = question_reg - 16'd1;
                        go_item       = 1'b1;
                    end
                    else
                        fbc_next = fbc_reg + 4'd1;
                end
                PH_RFIXED:
                begin
                    if (fbc_reg < 4'd2)
                        rtype_next = {rtype_next[COUNT_W-BYTE_W-1:0], data_byte};
                    else if (fbc_reg >= 4'd4 && fbc_reg < 4'd8)
                        ttl_next = {ttl_next[TTL_W-BYTE_W-1:0], data_byte};
                    else if (fbc_reg >= 4'd8)
                        rdata_next = {rdata_next[COUNT_W-BYTE_W-1:0], data_byte};
                    if (fbc_reg >= RFIXED_LAST)
                    begin
                        fbc_next = '0;
                        if (rdata_next == '0)
                            go_record = 1'b1;
                        else
                            phase_next = PH_RDATA;
                    end
                    else
                        fbc_next = fbc_reg + 4'd1;
                end
                PH_RDATA:
                begin
                    rdata_next = rdata_reg - 16'd1;
                    if (rdata_next == '0)
                        go_record = 1'b1;
                end
                default:
                begin
                end
            endcase

            // Close a record: count it off, capture the TTL on the first authority SOA.
            if (go_record)
            begin
                if (answer_next != '0)
                begin
                    answer_next = answer_next - 16'd1;
                    go_item     = 1'b1;
                end
                else
                begin
                    authority_next = authority_next - 16'd1;
                    if (rtype_next == SOA_TYPE)
                        phase_next = PH_FOUND;
                    else
                        go_item = 1'b1;
                end
            end

            if (go_name)
            begin
                fbc_next   = '0;
                phase_next = (question_next != '0) ? PH_QFIXED : PH_RFIXED;
            end

            if (go_item)
            begin
                fbc_next = '0;
                if (question_next != '0 || answer_next != '0 || authority_next != '0)
                    phase_next = PH_NAME;
                else
                    phase_next = PH_NONE;
            end

            if (last_byte)
            begin
                res_valid = 1'b1;
                if (phase_next == PH_FOUND)
                begin
                    res.status  = ST_FOUND;
                    res.soa_ttl = ttl_next;
                end
                else if (phase_next == PH_NONE)
                    res.status = ST_NO_SOA;
                else
                    res.status = ST_TRUNCATED;

                // Restart for the next message.
                phase_next     = PH_HEADER;
                fbc_next       = '0;
                question_next  = '0;
                answer_next    = '0;
                authority_next = '0;
                label_next     = '0;
                rtype_next     = '0;
                ttl_next       = '0;
                rdata_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fbc_reg       <= '0;
            question_reg  <= '0;
            answer_reg    <= '0;
            authority_reg <= '0;
            label_reg     <= '0;
            rtype_reg     <= '0;
            ttl_reg       <= '0;
            rdata_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fbc_reg       <= fbc_next;
            question_reg  <= question_next;
            answer_reg    <= answer_next;
            authority_reg <= authority_next;
            label_reg     <= label_next;
            rtype_reg     <= rtype_next;
            ttl_reg       <= ttl_next;
            rdata_reg     <= rdata_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dst_out.sv
// Result register that holds one result item until the receiver takes it.
`default_nettype none

module dst_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dst_pkg::result_t  res,
    output logic                   space,
    dst_result_if.source           result
);
    import dst_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign space      = !valid_reg || result.ready;
    assign valid_next = push || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload loads only on a push; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            res_reg <= res;
    end

    assign result.valid   = valid_reg;
    assign result.status  = res_reg.status;
    assign result.soa_ttl = res_reg.soa_ttl;

endmodule

`default_nettype wire

>>> hdl/dns_soa_ttl_extractor.sv
// DNS SOA TTL extractor: one response byte per item in, one result per message out.
//
// Channel msg (sink): data_byte plus last_byte, one message byte per item.
// Channel result (source): status (0 SOA found, 1 no SOA, 2 truncated) and
// soa_ttl, one item per message, produced by the byte marked last_byte.
// A byte is taken into an input register, walked through the parser state
// update when it advances from there, and a result lands in the output
// register in the same cycle as that update.
// Path: the last byte passes the input register, then the output register,
// whose valid bit drives result.valid.
// Throughput: one byte per cycle, unless a last byte is held for the result
// slot; the parser state update of one byte is the only recurrence.
// Stall: while a result waits in the output register, bytes keep flowing;
// only a last byte holds in the input register until the result slot frees,
// which drops msg.ready for that time.
// Reset: rst_n clears the parser to the header phase and empties both the
// input and the output register. After each result the parser restarts on
// its own, so the next byte opens a new message.
`default_nettype none

module dns_soa_ttl_extractor (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dst_byte_if.sink      msg,
    dst_result_if.source  result
);
    import dst_pkg::*;

    `include "dns_soa_ttl_extractor_macros.svh"

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic    consume;
    logic    out_space;
    logic    res_valid;
    result_t res;

    // Advance the held byte unless it ends a message and the result slot is full.
    assign consume       = in_valid_reg && (!in_last_reg || out_space);
    assign msg.ready     = !in_valid_reg || consume;
    assign in_valid_next = (msg.valid && msg.ready) || (in_valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            in_byte_reg <= msg.data_byte;
            in_last_reg <= msg.last_byte;
        end
    end

    dst_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dst_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_valid),
        .res    (res),
        .space  (out_space),
        .result (result)
    );

    `DST_ASSERT(a_push_has_space, res_valid |-> out_space, "result pushed into a full slot")
    `DST_ASSERT(a_held_byte_stays, in_valid_reg && !consume |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg), "held byte lost")
    `DST_ASSERT(a_ttl_zero_unless_found, result.valid && result.status != ST_FOUND |-> result.soa_ttl == '0, "TTL set without SOA")
    `DST_ASSERT(a_result_from_last, res_valid |-> consume && in_last_reg, "result without last byte")

endmodule

`default_nettype wire

>>> tb/dst_tb_pkg.sv
// Scoreboard class for the DNS SOA TTL extractor testbench.
`default_nettype none

package dst_tb_pkg;

    import dst_pkg::*;

    typedef enum logic [3:0] {
        PP_HEADER,
        PP_NAME,
        PP_LABEL,
        PP_PTR,
        PP_QFIXED,
        PP_RFIXED,
        PP_RDATA,
        PP_NONE,
        PP_FOUND
    } parse_phase_t;

    class soa_scoreboard;

        parse_phase_t       phase;
        logic [FBC_W-1:0]   fbc;
        logic [COUNT_W-1:0] q_left;
        logic [COUNT_W-1:0] an_left;
        logic [COUNT_W-1:0] ns_left;
        logic [BYTE_W-1:0]  lbl_left;
        logic [COUNT_W-1:0] rr_type;
        logic [TTL_W-1:0]   ttl_acc;
        logic [COUNT_W-1:0] rd_left;
        bit                 have_soa;
        logic [TTL_W-1:0]   soa_ttl_q;
        result_t            expected_q[$];
        int                 mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            phase     = PP_HEADER;
            fbc       = '0;
            q_left    = '0;
            an_left   = '0;
            ns_left   = '0;
            lbl_left  = '0;
            rr_type   = '0;
            ttl_acc   = '0;
            rd_left   = '0;
            have_soa  = 1'b0;
            soa_ttl_q = '0;
        endfunction

        function void start_item();
            fbc   = '0;
            phase = (q_left != 0 || an_left != 0 || ns_left != 0) ? PP_NAME : PP_NONE;
        endfunction

        function void name_end();
            fbc   = '0;
            phase = (q_left != 0) ? PP_QFIXED : PP_RFIXED;
        endfunction

        function void record_end();
            if (an_left != 0)
            begin
                an_left = an_left - 1'b1;
            end
            else
            begin
                ns_left = ns_left - 1'b1;
                if (rr_type == SOA_TYPE)
                begin
                    have_soa  = 1'b1;
                    soa_ttl_q = ttl_acc;
                    phase     = PP_FOUND;
                    return;
                end
            end
            start_item();
        endfunction

        // Advance the parser by one accepted byte; queue a result on the last one.
        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            result_t r;
            if (phase == PP_RFIXED && fbc == 0)
            begin
                rr_type = '0;
                ttl_acc = '0;
                rd_left = '0;
            end
            unique case (phase)
                PP_HEADER:
                begin
                    if (fbc == 4 || fbc == 5)
                        q_left = {q_left[7:0], b};
                    else if (fbc == 6 || fbc == 7)
                        an_left = {an_left[7:0], b};
                    else if (fbc == 8 || fbc == 9)
                        ns_left = {ns_left[7:0], b};
                    if (fbc >= HDR_LAST)
                        start_item();
                    else
                        fbc = fbc + 1'b1;
                end
                PP_NAME:
                begin
                    if ((b & PTR_MASK) == PTR_MASK)
                        phase = PP_PTR;
                    else if (b == NAME_END)
                        name_end();
                    else
                    begin
                        lbl_left = b;
                        phase    = PP_LABEL;
                    end
                end
                PP_LABEL:
                begin
                    lbl_left = lbl_left - 1'b1;
                    if (lbl_left == 0)
                        phase = PP_NAME;
                end
                PP_PTR:
                begin
                    name_end();
                end
                PP_QFIXED:
                begin
                    if (fbc >= QFIXED_LAST)
                    begin
                        q_left = q_left - 1'b1;
                        start_item();
                    end
                    else
                        fbc = fbc + 1'b1;
                end
                PP_RFIXED:
                begin
                    if (fbc < 2)
                        rr_type = {rr_type[7:0], b};
                    else if (fbc >= 4 && fbc < 8)
                        ttl_acc = {ttl_acc[23:0], b};
                    else if (fbc >= 8)
                        rd_left = {rd_left[7:0], b};
                    if (fbc >= RFIXED_LAST)
                    begin
                        fbc = '0;
                        if (rd_left == 0)
                            record_end();
                        else
                            phase = PP_RDATA;
                    end
                    else
                        fbc = fbc + 1'b1;
                end
                PP_RDATA:
                begin
                    rd_left = rd_left - 1'b1;
                    if (rd_left == 0)
                        record_end();
                end
                default:
                begin
                end
            endcase
            if (last)
            begin
                r.status  = have_soa ? ST_FOUND
                                     : ((phase == PP_NONE) ? ST_NO_SOA : ST_TRUNCATED);
                r.soa_ttl = have_soa ? soa_ttl_q : '0;
                expected_q.insert(expected_q.size(), r);
                clear();
            end
        endfunction

        // Compare one delivered result with the oldest queued one.
        function void check_result(logic [1:0] st, logic [TTL_W-1:0] ttl);
            result_t r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status %0d soa_ttl 0x%08h", st, ttl);
                mismatches++;
                return;
            end
            r = expected_q.pop_front();
            if (st !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, st);
                mismatches++;
            end
            if (ttl !== r.soa_ttl)
            begin
                $error("soa_ttl: expected 0x%08h, actual 0x%08h", r.soa_ttl, ttl);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

`default_nettype wire

>>> tb/tb_top.sv
// Top-level testbench of the DNS SOA TTL extractor.
`default_nettype none

module tb_top;

    import dst_pkg::*;
    import dst_tb_pkg::*;

    // Longest quiet stretch of a correct run is the forced result stall
    // (HOLD_CYCLES); STALL_LIMIT lies above it, so a correct run never calls a hang.
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_BYTES   = 360;
    localparam int RAND_MSGS    = 10;

    logic clk = 1'b0;
    logic rst_n;

    dst_byte_if   msg_ch ();
    dst_result_if res_ch ();

    dns_soa_ttl_extractor uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .result (res_ch)
    );

    soa_scoreboard sb;

    logic [7:0]  pkt[$];          // bytes of the message being built
    int          src_idle_pct;    // chance, redrawn each idle cycle, that the sender idles before an item
    int          sink_idle_pct;   // chance per cycle that the receiver stalls
    bit          hold_req;        // ask the receiver for one long stall
    int unsigned quiet_cycles;
    int unsigned bytes_sent;
    int unsigned msgs_sent;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------

    // Append one byte to the message being built.
    task automatic add_byte(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endtask

    task automatic put16(input logic [15:0] v);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endtask

    // Append a name: nlabels short labels, then either a root byte or a
    // two-byte compression pointer.
    task automatic add_name(input int nlabels, input bit ptr_end);
        int n;
        int len;
        for (n = 0; n < nlabels; n++)
        begin
            len = $urandom_range(1, 4);
            add_byte(8'(len));
            repeat (len) add_byte(8'($urandom));
        end
        if (ptr_end)
        begin
            add_byte(PTR_MASK | 8'($urandom_range(0, 63)));
            add_byte(8'($urandom));
        end
        else
            add_byte(NAME_END);
    endtask

    // Header with random id, flags and additional count.
    task automatic add_header(input logic [15:0] qd, input logic [15:0] an,
                              input logic [15:0] ns);
        put16(16'($urandom));
        put16(16'($urandom));
        put16(qd);
        put16(an);
        put16(ns);
        put16(16'($urandom_range(0, 3)));
    endtask

    task automatic add_question();
        add_name($urandom_range(0, 2), 1'($urandom_range(0, 1)));
        put16(16'($urandom));
        put16(16'($urandom));
    endtask

    task automatic add_record(input logic [15:0] rtype, input logic [31:0] ttl,
                              input logic [15:0] rdlen, input bit ptr_name);
        add_name($urandom_range(0, 2), ptr_name);
        put16(rtype);
        put16(16'($urandom));
        put16(ttl[31:16]);
        put16(ttl[15:0]);
        put16(rdlen);
        repeat (rdlen) add_byte(8'($urandom));
    endtask

    function automatic logic [31:0] pick_ttl();
        unique case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_type();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(1, 16));
    endfunction

    // Mostly well-formed responses with random content; the rest are cut
    // short at a random byte or are plain noise.
    task automatic build_random_message();
        int kind;
        int qd;
        int an;
        int ns;
        int keep;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
        end
        else
        begin
            qd = $urandom_range(0, 1);
            an = $urandom_range(0, 1);
            ns = $urandom_range(0, 2);
            add_header(16'(qd), 16'(an), 16'(ns));
            repeat (qd) add_question();
            repeat (an)
                add_record(pick_type(), pick_ttl(), 16'($urandom_range(0, 4)),
                           1'($urandom_range(0, 1)));
            repeat (ns)
                add_record(($urandom_range(0, 1) == 0) ? SOA_TYPE : pick_type(),
                           pick_ttl(), 16'($urandom_range(0, 4)),
                           1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
            if (kind == 1)
            begin
                keep = $urandom_range(1, pkt.size());
                while (pkt.size() > keep) void'(pkt.pop_back());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer every byte of pkt in order, marking the final one, then clear it.
    // Hold each byte until the handshake; idle between bytes at random.
    task automatic send_message();
        int i;
        for (i = 0; i < pkt.size(); i++)
        begin
            while ($urandom_range(0, 99) < src_idle_pct)
            begin
                msg_ch.valid <= 1'b0;
                @(posedge clk);
            end
            msg_ch.valid     <= 1'b1;
            msg_ch.data_byte <= pkt[i];
            msg_ch.last_byte <= (i == pkt.size() - 1);
            do
                @(posedge clk);
            while (!msg_ch.ready);
        end
        bytes_sent += pkt.size();
        msgs_sent++;
        pkt.delete();
    endtask

    // Receiver: stall at random, or for HOLD_CYCLES when asked, so that the
    // output register fills and the held last byte backs up the input.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitoring: all samples are taken at the rising edge, before the
    // block's registers update, so they show the values of the handshake.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            quiet_cycles = 0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.status, res_ch.soa_ttl);
            if (msg_ch.valid && msg_ch.ready)
                sb.note_byte(msg_ch.data_byte, msg_ch.last_byte);
            if ((res_ch.valid && res_ch.ready) || (msg_ch.valid && msg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int ph;
        int unsigned phase_start;
        int unsigned rand_msg_start;

        sb               = new();
        rst_n            = 1'b0;
        hold_req         = 1'b0;
        quiet_cycles     = 0;
        bytes_sent       = 0;
        msgs_sent        = 0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        msg_ch.valid     <= 1'b0;
        msg_ch.data_byte <= '0;
        msg_ch.last_byte <= 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages, no idling.

        // Message of one byte: ends in the header.
        add_byte(8'hFF);
        send_message();

        // Header cut one byte short.
        add_header(16'd0, 16'd0, 16'd1);
        void'(pkt.pop_back());
        send_message();

        // All counts zero: nothing to find.
        add_header(16'd0, 16'd0, 16'd0);
        send_message();

        // All counts zero, then trailing bytes at both byte extremes.
        add_header(16'd0, 16'd0, 16'd0);
        add_byte(8'h00);
        add_byte(8'hFF);
        send_message();

        // SOA type in the answer section is skipped; authority SOA with the
        // largest TTL ends exactly on its last rdata byte.
        add_header(16'd1, 16'd1, 16'd1);
        add_question();
        add_record(SOA_TYPE, 32'h0BAD_CAFE, 16'd2, 1'b0);
        add_record(SOA_TYPE, 32'hFFFF_FFFF, 16'd3, 1'b1);
        send_message();

        // Non-SOA authority record, then SOA with TTL zero and no rdata,
        // pointer names, then trailing bytes after the capture.
        add_header(16'd0, 16'd0, 16'd2);
        add_record(16'd2, 32'h1234_5678, 16'd1, 1'b1);
        add_record(SOA_TYPE, 32'h0000_0000, 16'd0, 1'b1);
        repeat (3) add_byte(8'($urandom));
        send_message();

        // Label length bytes with top bits 01 and 10 are plain lengths.
        add_header(16'd1, 16'd0, 16'd1);
        add_byte(8'h40);
        repeat (64) add_byte(8'($urandom));
        add_byte(8'h80);
        repeat (128) add_byte(8'($urandom));
        add_byte(NAME_END);
        put16(16'($urandom));
        put16(16'($urandom));
        add_record(SOA_TYPE, 32'hA5C3_0F96, 16'd2, 1'b0);
        send_message();

        // SOA record cut inside its rdata: not complete, so truncated.
        add_header(16'd0, 16'd0, 16'd1);
        add_record(SOA_TYPE, 32'h0101_0101, 16'd4, 1'b0);
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        send_message();

        // Two authority records, neither SOA.
        add_header(16'd0, 16'd0, 16'd2);
        add_record(16'd1, 32'hDEAD_BEEF, 16'd4, 1'b0);
        add_record(16'h0600, 32'h7FFF_FFFF, 16'd0, 1'b1);
        send_message();

        // Long rdata with a non-zero high length byte, then an SOA.
        add_header(16'd0, 16'd1, 16'd1);
        add_record(16'd16, 32'h8000_0000, 16'h0102, 1'b0);
        add_record(SOA_TYPE, 32'h0000_0001, 16'd1, 1'b0);
        send_message();

        // Huge counts: the message always ends early.
        add_header(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_question();
        send_message();

        // Random part in three stretches: receiver-heavy idling, sender-heavy
        // idling, then none. The last stretch opens with a long receiver
        // stall while short messages keep coming, and runs on until enough
        // messages have been sent.
        rand_msg_start = msgs_sent;
        for (ph = 0; ph < 3; ph++)
        begin
            unique case (ph)
                0:
                begin
                    src_idle_pct  = 32;
                    sink_idle_pct = 67;
                end
                1:
                begin
                    src_idle_pct  = 67;
                    sink_idle_pct = 32;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    hold_req      = 1'b1;
                    repeat (6)
                    begin
                        add_byte(8'($urandom));
                        send_message();
                    end
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RAND_BYTES / 3 ||
                   (ph == 2 && msgs_sent - rand_msg_start < RAND_MSGS))
            begin
                build_random_message();
                send_message();
            end
        end

        // Drain: drop valid, wait for every queued result, then a short tail
        // to catch anything extra.
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
